FILE: hdl/cab_pkg.sv
package cab_pkg;

  // Field widths
  localparam int COORD_W = 12;
  localparam int PIX_W   = 32;
  localparam int OP_W    = 3;
  localparam int CHAN_W  = 8;
  localparam int MIX_W   = 2 * CHAN_W;

  // Defaults for the top level parameters
  localparam int SCREEN_WIDTH_DEF  = 320;
  localparam int SCREEN_HEIGHT_DEF = 240;
  localparam int CLIP_DEPTH_DEF    = 8;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'h00;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_SET_CLIP = 3'd0,
    OP_PUSH     = 3'd1,
    OP_POP      = 3'd2,
    OP_BLEND    = 3'd3,
    OP_FILL     = 3'd4
  } op_t;

  // What the back end does with a word
  typedef enum logic [1:0] {
    WK_NONE = 2'd0,
    WK_COPY = 2'd1,
    WK_MIX  = 2'd2
  } wr_kind_t;

  // Clip rectangle, edges inclusive, two's complement
  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
  } rect_t;

  localparam int RECT_W = $bits(rect_t);

  localparam rect_t EMPTY_RECT = '{left: '0, top: '0, right: '1, bottom: '1};

  // Classified word handed from front to back
  typedef struct packed {
    wr_kind_t         kind;
    logic [PIX_W-1:0] src;
    logic [PIX_W-1:0] dst;
    logic             clip_empty;
  } work_t;

  function automatic logic rect_is_empty(input rect_t r);
    rect_is_empty = ($signed(r.right) < $signed(r.left)) ||
                    ($signed(r.bottom) < $signed(r.top));
  endfunction

endpackage

FILE: hdl/clipped_argb_blend_unit.sv
// Clipped ARGB8888 compositing unit, one word per pixel or clip command.
// Input channel (in_valid/in_ready) carries operation, coordinates and the
// source and destination pixels; output channel (out_valid/out_ready)
// returns write_enable, pixel_out and clip_empty, one word per input word,
// in order. pixel_out is zero whenever write_enable is low.
// Throughput: one word per cycle, for every operation, pops included, while out_ready stays high.
// Path from input accept to output valid: the clip front end, a two-word queue,
// a multiply stage and the output register.
// The clip rectangle and stack are updated in the front end in the accept
// cycle; the stack lives in a RAM whose next-to-top entry is prefetched so a
// pop following any word proceeds without a bubble.
// When out_ready is low the back end holds its words and the queue fills;
// in_ready falls once the queue holds two words.
// Reset (rst, synchronous): clip is the full screen, the stack is empty, no
// words are in flight. Stack entries are undefined until pushed.
module clipped_argb_blend_unit import cab_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int CLIP_DEPTH    = CLIP_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    operation,
  input  logic [COORD_W-1:0] coord_a,
  input  logic [COORD_W-1:0] coord_b,
  input  logic [COORD_W-1:0] coord_c,
  input  logic [COORD_W-1:0] coord_d,
  input  logic [PIX_W-1:0]   source_pixel,
  input  logic [PIX_W-1:0]   dest_pixel,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               write_enable,
  output logic [PIX_W-1:0]   pixel_out,
  output logic               clip_empty
);

  logic  fq_valid, fq_ready;
  work_t fq_word;
  logic  qb_valid, qb_ready;
  work_t qb_word;

  cab_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .CLIP_DEPTH    (CLIP_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .coord_a      (coord_a),
    .coord_b      (coord_b),
    .coord_c      (coord_c),
    .coord_d      (coord_d),
    .source_pixel (source_pixel),
    .dest_pixel   (dest_pixel),
    .q_valid      (fq_valid),
    .q_ready      (fq_ready),
    .q_word       (fq_word)
  );

  cab_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_word  (fq_word),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_word   (qb_word)
  );

  cab_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (qb_valid),
    .q_ready      (qb_ready),
    .q_word       (qb_word),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .write_enable (write_enable),
    .pixel_out    (pixel_out),
    .clip_empty   (clip_empty)
  );

  // No write is ever classified while the clip is empty
  a_no_write_when_empty: assert property (@(posedge clk) disable iff (rst)
    fq_valid && fq_ready && (fq_word.kind != WK_NONE) |-> !fq_word.clip_empty)
    else $error("write classified with an empty clip");

  // A word without a write carries a zero pixel
  a_zero_pixel: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_enable |-> (pixel_out == '0))
    else $error("nonzero pixel without write enable");

  // A mix is classified only for a source that is neither opaque nor clear
  a_mix_opaque: assert property (@(posedge clk) disable iff (rst)
    fq_valid && fq_ready && (fq_word.kind == WK_MIX) |->
      (fq_word.src[PIX_W-1 -: CHAN_W] != ALPHA_OPAQUE) &&
      (fq_word.src[PIX_W-1 -: CHAN_W] != ALPHA_CLEAR))
    else $error("mix classified for an opaque or clear source");

endmodule

FILE: hdl/cab_ram.sv
module cab_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, old data on a same-cycle write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/cab_front.sv
module cab_front import cab_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int CLIP_DEPTH    = CLIP_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    operation,
  input  logic [COORD_W-1:0] coord_a,
  input  logic [COORD_W-1:0] coord_b,
  input  logic [COORD_W-1:0] coord_c,
  input  logic [COORD_W-1:0] coord_d,
  input  logic [PIX_W-1:0]   source_pixel,
  input  logic [PIX_W-1:0]   dest_pixel,
  output logic               q_valid,
  input  logic               q_ready,
  output work_t              q_word
);

  localparam int CNT_W     = $clog2(CLIP_DEPTH + 1);
  localparam int AW        = (CLIP_DEPTH > 1) ? $clog2(CLIP_DEPTH) : 1;
  localparam int RAM_DEPTH = 1 << AW;

  localparam logic [COORD_W-1:0] X_MAX = COORD_W'(SCREEN_WIDTH - 1);
  localparam logic [COORD_W-1:0] Y_MAX = COORD_W'(SCREEN_HEIGHT - 1);
  localparam logic [CNT_W-1:0]   CNT_FULL = CNT_W'(CLIP_DEPTH);
  localparam rect_t FULL_RECT = '{left: '0, top: '0, right: X_MAX, bottom: Y_MAX};

  logic             accept;
  rect_t            clip, clip_next;
  rect_t            top_entry, top_next;
  logic [CNT_W-1:0] stack_count, count_next;
  logic [CNT_W-1:0] rd_sub;
  logic             push_en;
  rect_t            rd_rect;
  rect_t            set_rect;
  logic [COORD_W-1:0] cl_l, cl_t, cl_r, cl_b;
  logic             in_clip;
  wr_kind_t         kind;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;

  // Clamp a new clip to the screen; inverted becomes empty
  always_comb begin
    cl_l = coord_a[COORD_W-1] ? '0 : coord_a;
    cl_t = coord_b[COORD_W-1] ? '0 : coord_b;
    cl_r = ($signed(coord_c) > $signed(X_MAX)) ? X_MAX : coord_c;
    cl_b = ($signed(coord_d) > $signed(Y_MAX)) ? Y_MAX : coord_d;
    if (($signed(cl_r) < $signed(cl_l)) || ($signed(cl_b) < $signed(cl_t))) begin
      set_rect = EMPTY_RECT;
    end else begin
      set_rect = '{left: cl_l, top: cl_t, right: cl_r, bottom: cl_b};
    end
  end

  // Clip and stack update
  always_comb begin
    clip_next  = clip;
    top_next   = top_entry;
    count_next = stack_count;
    push_en    = 1'b0;
    if (accept) begin
      case (operation)
        OP_SET_CLIP: begin
          clip_next = set_rect;
        end
        OP_PUSH: begin
          if (stack_count < CNT_FULL) begin
            push_en    = 1'b1;
            top_next   = clip;
            count_next = stack_count + CNT_W'(1);
          end
        end
        OP_POP: begin
          if (stack_count != '0) begin
            clip_next  = top_entry;
            top_next   = rd_rect;
            count_next = stack_count - CNT_W'(1);
          end else begin
            clip_next = FULL_RECT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Memory keeps the entry under the top ready for the next pop
  assign rd_sub = count_next - CNT_W'(2);

  cab_ram #(
    .WIDTH (RECT_W),
    .DEPTH (RAM_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk   (clk),
    .we    (push_en),
    .waddr (stack_count[AW-1:0]),
    .wdata (clip),
    .raddr (rd_sub[AW-1:0]),
    .rdata (rd_rect)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clip        <= FULL_RECT;
      stack_count <= '0;
    end else begin
      clip        <= clip_next;
      stack_count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    top_entry <= top_next;
  end

  // Classify pixel operations against the current clip
  assign in_clip = !rect_is_empty(clip) &&
                   ($signed(coord_a) >= $signed(clip.left)) &&
                   ($signed(coord_a) <= $signed(clip.right)) &&
                   ($signed(coord_b) >= $signed(clip.top)) &&
                   ($signed(coord_b) <= $signed(clip.bottom));

  always_comb begin
    kind = WK_NONE;
    case (operation)
      OP_FILL: begin
        if (in_clip) kind = WK_COPY;
      end
      OP_BLEND: begin
        if (in_clip) begin
          if (source_pixel[PIX_W-1 -: CHAN_W] == ALPHA_OPAQUE) begin
            kind = WK_COPY;
          end else if (source_pixel[PIX_W-1 -: CHAN_W] != ALPHA_CLEAR) begin
            kind = WK_MIX;
          end
        end
      end
      default: begin
        kind = WK_NONE;
      end
    endcase
  end

  assign q_valid = in_valid;
  assign q_word  = '{kind: kind, src: source_pixel, dst: dest_pixel,
                     clip_empty: rect_is_empty(clip_next)};

endmodule

FILE: hdl/cab_queue.sv
module cab_queue import cab_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  work_t push_word,
  output logic  pop_valid,
  input  logic  pop_ready,
  output work_t pop_word
);

  work_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push, do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_word   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_word;
    end
  end

endmodule

FILE: hdl/cab_back.sv
module cab_back import cab_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_ready,
  input  work_t            q_word,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             write_enable,
  output logic [PIX_W-1:0] pixel_out,
  output logic             clip_empty
);

  localparam int NCH = 3;

  logic              s1_valid, s1_ready, out_load;
  wr_kind_t          s1_kind;
  logic [PIX_W-1:0]  s1_src;
  logic              s1_empty;
  logic [MIX_W-1:0]  s1_mix [NCH];
  logic [MIX_W-1:0]  mix_next [NCH];
  logic [CHAN_W-1:0] alpha, alpha_inv;
  logic [MIX_W-1:0]  quot [NCH];
  logic [PIX_W-1:0]  pix_next;

  assign out_load = !out_valid || out_ready;
  assign s1_ready = !s1_valid || out_load;
  assign q_ready  = s1_ready;

  // Stage 1: sa*s + (255-sa)*d per channel
  assign alpha     = q_word.src[PIX_W-1 -: CHAN_W];
  assign alpha_inv = ALPHA_OPAQUE - alpha;

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      mix_next[ch] = MIX_W'(alpha) * MIX_W'(q_word.src[ch*CHAN_W +: CHAN_W]) +
                     MIX_W'(alpha_inv) * MIX_W'(q_word.dst[ch*CHAN_W +: CHAN_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && q_valid) begin
      s1_kind  <= q_word.kind;
      s1_src   <= q_word.src;
      s1_empty <= q_word.clip_empty;
      for (int ch = 0; ch < NCH; ch++) begin
        s1_mix[ch] <= mix_next[ch];
      end
    end
  end

  // Stage 2: x/255 as (x + (x>>8) + 1) >> 8, exact below 65280 in the 16-bit sum
  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      quot[ch] = s1_mix[ch] + MIX_W'(s1_mix[ch][MIX_W-1 -: CHAN_W]) + MIX_W'(1);
    end
  end

  always_comb begin
    case (s1_kind)
      WK_COPY: pix_next = s1_src;
      WK_MIX:  pix_next = {ALPHA_OPAQUE, quot[2][MIX_W-1 -: CHAN_W],
                           quot[1][MIX_W-1 -: CHAN_W], quot[0][MIX_W-1 -: CHAN_W]};
      default: pix_next = '0;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      write_enable <= (s1_kind != WK_NONE);
      pixel_out    <= pix_next;
      clip_empty   <= s1_empty;
    end
  end

endmodule

FILE: tb/sv/tb_clipped_argb_blend_unit.sv
`timescale 1ns / 100ps

module tb_clipped_argb_blend_unit;
  import cab_pkg::*;

  localparam int SCREEN_W   = SCREEN_WIDTH_DEF;
  localparam int SCREEN_H   = SCREEN_HEIGHT_DEF;
  localparam int STACK_MAX  = CLIP_DEPTH_DEF;
  localparam int CYCLE_CAP  = 400000;
  localparam int HOLD_LEN   = 300;
  localparam int PRINT_CAP  = 60;

  // Operation codes the block must ignore
  localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_LAST  = 3'd7;

  typedef struct {
    logic             write_en;
    logic [PIX_W-1:0] pixel;
    logic             empty;
  } pixel_word_t;

  typedef struct {
    int l;
    int t;
    int r;
    int b;
  } clip_box_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [OP_W-1:0]    operation;
  logic [COORD_W-1:0] coord_a;
  logic [COORD_W-1:0] coord_b;
  logic [COORD_W-1:0] coord_c;
  logic [COORD_W-1:0] coord_d;
  logic [PIX_W-1:0]   source_pixel;
  logic [PIX_W-1:0]   dest_pixel;
  logic               out_valid;
  logic               out_ready;
  logic               write_enable;
  logic [PIX_W-1:0]   pixel_out;
  logic               clip_empty;

  clipped_argb_blend_unit uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .coord_a      (coord_a),
    .coord_b      (coord_b),
    .coord_c      (coord_c),
    .coord_d      (coord_d),
    .source_pixel (source_pixel),
    .dest_pixel   (dest_pixel),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .write_enable (write_enable),
    .pixel_out    (pixel_out),
    .clip_empty   (clip_empty)
  );

  // Shadow of the clip rectangle and the clip stack
  clip_box_t   cur_clip;
  clip_box_t   saved_clips [STACK_MAX];
  int          saved_count;

  pixel_word_t pending_pixels [$];
  pixel_word_t got_word;
  pixel_word_t want_word;
  int          fail_count;
  int          cycle_count;
  bit          tx_idle_en;
  bit          rx_idle_en;
  bit          hold_req;

  // Clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("%0t timeout after %0d cycles, %0d words outstanding", $time, cycle_count,
               pending_pixels.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit clip_is_void(input clip_box_t c);
    return (c.r < c.l) || (c.b < c.t);
  endfunction

  function automatic logic [CHAN_W-1:0] mix_chan(input int sa, input int s, input int d);
    return CHAN_W'((sa * s + (255 - sa) * d) / 255);
  endfunction

  function automatic void reset_clip_model();
    cur_clip = '{l: 0, t: 0, r: SCREEN_W - 1, b: SCREEN_H - 1};
    saved_count = 0;
  endfunction

  // Apply one word to the shadow state and return what the block must write
  function automatic pixel_word_t blend_outcome(input logic [OP_W-1:0] op,
      input logic [COORD_W-1:0] ca, input logic [COORD_W-1:0] cb,
      input logic [COORD_W-1:0] cc, input logic [COORD_W-1:0] cd,
      input logic [PIX_W-1:0] src, input logic [PIX_W-1:0] dst);
    int          a;
    int          b;
    int          c;
    int          d;
    int          sa;
    bit          hit;
    pixel_word_t res;
    a = $signed(ca);
    b = $signed(cb);
    c = $signed(cc);
    d = $signed(cd);
    res.write_en = 1'b0;
    res.pixel = '0;
    case (op)
      OP_SET_CLIP: begin
        if (a < 0) a = 0;
        if (b < 0) b = 0;
        if (c >= SCREEN_W) c = SCREEN_W - 1;
        if (d >= SCREEN_H) d = SCREEN_H - 1;
        if (c < a || d < b) cur_clip = '{l: 0, t: 0, r: -1, b: -1};
        else cur_clip = '{l: a, t: b, r: c, b: d};
      end
      OP_PUSH: begin
        if (saved_count < STACK_MAX) begin
          saved_clips[saved_count] = cur_clip;
          saved_count++;
        end
      end
      OP_POP: begin
        if (saved_count > 0) begin
          saved_count--;
          cur_clip = saved_clips[saved_count];
        end else begin
          cur_clip = '{l: 0, t: 0, r: SCREEN_W - 1, b: SCREEN_H - 1};
        end
      end
      OP_BLEND, OP_FILL: begin
        hit = !clip_is_void(cur_clip) && a >= cur_clip.l && a <= cur_clip.r &&
              b >= cur_clip.t && b <= cur_clip.b;
        sa = src[31:24];
        if (hit) begin
          if (op == OP_FILL || src[31:24] == ALPHA_OPAQUE) begin
            res.write_en = 1'b1;
            res.pixel = src;
          end else if (src[31:24] != ALPHA_CLEAR) begin
            res.write_en = 1'b1;
            res.pixel = {ALPHA_OPAQUE, mix_chan(sa, src[23:16], dst[23:16]),
                         mix_chan(sa, src[15:8], dst[15:8]), mix_chan(sa, src[7:0], dst[7:0])};
          end
        end
      end
      default: ;
    endcase
    res.empty = clip_is_void(cur_clip);
    return res;
  endfunction

  // ---------------------------------------------------------------- driver

  // Offer one word, wait for it to be taken, then record what it must produce
  task automatic send_word(input logic [OP_W-1:0] op,
      input logic [COORD_W-1:0] ca, input logic [COORD_W-1:0] cb,
      input logic [COORD_W-1:0] cc, input logic [COORD_W-1:0] cd,
      input logic [PIX_W-1:0] src, input logic [PIX_W-1:0] dst);
    int gap;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    coord_a      <= ca;
    coord_b      <= cb;
    coord_c      <= cc;
    coord_d      <= cd;
    source_pixel <= src;
    dest_pixel   <= dst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_pixels.push_back(blend_outcome(op, ca, cb, cc, cd, src, dst));
  endtask

  // Mostly around the screen, sometimes anywhere in the 12-bit range
  function automatic logic [COORD_W-1:0] near_coord(input int span);
    if ($urandom_range(0, 7) == 0) return COORD_W'($urandom);
    return COORD_W'($urandom_range(0, span + 80) - 40);
  endfunction

  // Close to a clip interval, edges included
  function automatic logic [COORD_W-1:0] around(input int lo, input int hi);
    return COORD_W'(int'($urandom_range(0, hi - lo + 4)) + lo - 2);
  endfunction

  // Source pixel with the alpha special cases well represented
  function automatic logic [PIX_W-1:0] rand_src();
    case ($urandom_range(0, 3))
      0:       return {ALPHA_CLEAR, 24'($urandom)};
      1:       return {ALPHA_OPAQUE, 24'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic send_pixel_op(input logic [OP_W-1:0] op);
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    if (!clip_is_void(cur_clip) && $urandom_range(0, 1) == 0) begin
      x = around(cur_clip.l, cur_clip.r);
      y = around(cur_clip.t, cur_clip.b);
    end else begin
      x = near_coord(SCREEN_W);
      y = near_coord(SCREEN_H);
    end
    send_word(op, x, y, COORD_W'($urandom), COORD_W'($urandom), rand_src(), $urandom);
  endtask

  task automatic send_rand_clip();
    logic [COORD_W-1:0] l;
    logic [COORD_W-1:0] t;
    l = near_coord(SCREEN_W);
    t = near_coord(SCREEN_H);
    if ($urandom_range(0, 3) == 0)
      send_word(OP_SET_CLIP, l, t, near_coord(SCREEN_W), near_coord(SCREEN_H),
                $urandom, $urandom);
    else
      send_word(OP_SET_CLIP, l, t, l + COORD_W'($urandom_range(0, 140)) - 12'd8,
                t + COORD_W'($urandom_range(0, 100)) - 12'd8, $urandom, $urandom);
  endtask

  task automatic send_rand_word();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) send_rand_clip();
    else if (pick < 16) send_word(OP_PUSH, COORD_W'($urandom), COORD_W'($urandom),
                                  COORD_W'($urandom), COORD_W'($urandom), $urandom, $urandom);
    else if (pick < 24) send_word(OP_POP, COORD_W'($urandom), COORD_W'($urandom),
                                  COORD_W'($urandom), COORD_W'($urandom), $urandom, $urandom);
    else if (pick < 62) send_pixel_op(OP_BLEND);
    else if (pick < 97) send_pixel_op(OP_FILL);
    else send_word(OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST)), COORD_W'($urandom),
                   COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                   $urandom, $urandom);
  endtask

  // ---------------------------------------------------------------- receiver

  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        // long hold-off: queue fills and the input stalls
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------- checker

  task automatic check_field(input string name, input logic [PIX_W-1:0] want,
      input logic [PIX_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= PRINT_CAP)
        $display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_word.write_en = write_enable;
      got_word.pixel = pixel_out;
      got_word.empty = clip_empty;
      if (pending_pixels.size() == 0) begin
        fail_count++;
        if (fail_count <= PRINT_CAP)
          $display("%0t unexpected word: expected none, actual we=%b pix=%h empty=%b",
                   $time, write_enable, pixel_out, clip_empty);
      end else begin
        want_word = pending_pixels.pop_front();
        check_field("write_enable", PIX_W'(want_word.write_en), PIX_W'(got_word.write_en));
        check_field("pixel_out", want_word.pixel, got_word.pixel);
        check_field("clip_empty", PIX_W'(want_word.empty), PIX_W'(got_word.empty));
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // Screen edges, alpha cases, clamping, empty clip, pop on empty stack
  task automatic test_directed();
    send_word(OP_FILL, 12'd0, 12'd0, 12'h7FF, 12'h800, 32'hFFFF_FFFF, 32'h0000_0000);
    send_word(OP_FILL, 12'd319, 12'd239, 12'h800, 12'h7FF, 32'h0000_0000, 32'hFFFF_FFFF);
    send_word(OP_FILL, 12'd320, 12'd5, 12'd0, 12'd0, 32'h1234_5678, 32'h0);
    send_word(OP_FILL, 12'h800, 12'h800, 12'd0, 12'd0, 32'h89AB_CDEF, 32'h0);
    send_word(OP_BLEND, 12'd10, 12'd240, 12'd0, 12'd0, 32'hFF11_2233, 32'h0);
    send_word(OP_BLEND, 12'd10, 12'd10, 12'd0, 12'd0, 32'hFF11_2233, 32'h4455_6677);
    send_word(OP_BLEND, 12'd10, 12'd10, 12'd0, 12'd0, 32'h00FF_FFFF, 32'h4455_6677);
    send_word(OP_BLEND, 12'd11, 12'd12, 12'd0, 12'd0, 32'h80FF_00FF, 32'h0000_FF00);
    send_word(OP_BLEND, 12'd12, 12'd11, 12'd0, 12'd0, 32'h01FF_FFFF, 32'hFF00_0000);
    send_word(OP_BLEND, 12'd13, 12'd13, 12'd0, 12'd0, 32'hFEFF_FFFF, 32'hFFFF_FFFF);
    // clamped to the full screen
    send_word(OP_SET_CLIP, 12'h800, 12'h800, 12'h7FF, 12'h7FF, 32'h0, 32'h0);
    // right left of left: empty
    send_word(OP_SET_CLIP, 12'd100, 12'd50, 12'd99, 12'd60, 32'h0, 32'h0);
    send_word(OP_FILL, 12'd100, 12'd50, 12'd0, 12'd0, 32'hCAFE_F00D, 32'h0);
    // pop with nothing saved restores the full screen
    send_word(OP_POP, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 32'h0);
    send_word(OP_SET_CLIP, 12'd5, 12'd5, 12'd5, 12'd5, 32'h0, 32'h0);
    send_word(OP_FILL, 12'd5, 12'd5, 12'd0, 12'd0, 32'hA5A5_5A5A, 32'h0);
    send_word(OP_FILL, 12'd6, 12'd5, 12'd0, 12'd0, 32'hA5A5_5A5A, 32'h0);
    send_word(OP_PUSH, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 32'h0);
    // bottom clamps to a row above the top: empty
    send_word(OP_SET_CLIP, 12'd0, 12'd240, 12'd10, 12'h7FF, 32'h0, 32'h0);
    send_word(OP_POP, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 32'h0);
    send_word(OP_FILL, 12'd5, 12'd4, 12'd0, 12'd0, 32'h5A5A_A5A5, 32'h0);
    send_word(OP_RSVD_LAST, 12'd5, 12'd5, 12'd5, 12'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_RSVD_FIRST, 12'd5, 12'd5, 12'd5, 12'd5, 32'hFF00_0000, 32'h0);
    send_word(OP_POP, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 32'h0);
  endtask

  // Fill the stack past its depth, then unwind two further than it holds
  task automatic test_stack_depth();
    for (int i = 0; i <= STACK_MAX; i++) begin
      send_rand_clip();
      send_word(OP_PUSH, 12'd0, 12'd0, 12'd0, 12'd0, $urandom, $urandom);
    end
    for (int i = 0; i <= STACK_MAX + 1; i++) begin
      send_word(OP_POP, 12'd0, 12'd0, 12'd0, 12'd0, $urandom, $urandom);
      send_pixel_op(OP_FILL);
    end
  endtask

  task automatic test_random_mix(input int count);
    for (int i = 0; i < count; i++) send_rand_word();
  endtask

  // Nested push / set clip / draw / pop sequences with random content
  task automatic test_nested_clips(input int sequences);
    int depth;
    int draws;
    for (int s = 0; s < sequences; s++) begin
      depth = $urandom_range(1, STACK_MAX + 2);
      for (int lv = 0; lv < depth; lv++) begin
        send_word(OP_PUSH, COORD_W'($urandom), COORD_W'($urandom), 12'd0, 12'd0,
                  $urandom, $urandom);
        send_rand_clip();
        draws = $urandom_range(0, 3);
        for (int k = 0; k < draws; k++)
          send_pixel_op($urandom_range(0, 1) ? OP_BLEND : OP_FILL);
      end
      for (int lv = 0; lv < depth + int'($urandom_range(0, 1)); lv++) begin
        send_word(OP_POP, COORD_W'($urandom), COORD_W'($urandom), 12'd0, 12'd0,
                  $urandom, $urandom);
        if ($urandom_range(0, 1) == 0) send_pixel_op(OP_BLEND);
      end
      if ($urandom_range(0, 9) == 0) send_rand_word();
    end
  endtask

  // Receiver holds off for a long stretch while words keep coming
  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_rand_word();
    tx_idle_en = 1'b1;
  endtask

  // Main sequence
  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    operation    = '0;
    coord_a      = '0;
    coord_b      = '0;
    coord_c      = '0;
    coord_d      = '0;
    source_pixel = '0;
    dest_pixel   = '0;
    fail_count   = 0;
    cycle_count  = 0;
    tx_idle_en   = 1'b1;
    rx_idle_en   = 1'b1;
    hold_req     = 1'b0;
    reset_clip_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_stack_depth();
    test_random_mix(500);
    test_backpressure();
    test_nested_clips(25);
    test_random_mix(300);
    // last part runs at full rate on both sides
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_mix(250);

    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
